### rtl/nwc_pkg.sv
// nwc_pkg: shared types and constants for the nngp whiten/color block
// command and status structs between controller and datapath
package nwc_pkg;

  localparam int unsigned IdxW   = 12;
  localparam int unsigned ValW   = 32;
  localparam int unsigned SumW   = 64;
  localparam int unsigned RootW  = 24;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CntW   = 6;

  localparam logic [StatW-1:0] StatOk      = 2'd0;
  localparam logic [StatW-1:0] StatSat     = 2'd1;
  localparam logic [StatW-1:0] StatZeroVar = 2'd2;

  localparam logic [CntW-1:0] SqrtIters = CntW'(RootW - 1);
  localparam logic [CntW-1:0] DivIters  = CntW'(SumW - 1);

  localparam logic DirWhiten = 1'b0;
  localparam logic DirColor  = 1'b1;

  typedef struct packed {
    logic load;
    logic mul_term;
    logic acc_term;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic mul_col;
    logic acc_col;
    logic finish;
  } nwc_cmd_t;

  typedef struct packed {
    logic has_term;
    logic last_term;
    logic zero_var;
    logic out_free;
    logic dir;
  } nwc_stat_t;

endpackage

### rtl/nngp_whiten_color.sv
// nngp_whiten_color: one item at a time; each item is read and, with a term, multiplied
// and accumulated; a last term runs a bit-serial square root (skipped at zero variance)
// and then a bit-serial divide (whiten) or a multiply and accumulate (color) before finish
// a result waits in the output register while the next item is taken
// reset clears control, the term sum and direction; the value store is not cleared
module nngp_whiten_color
  import nwc_pkg::*;
#(
  parameter int unsigned NUM_LOCATIONS = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [IdxW-1:0]        location_i,
  input  logic signed [ValW-1:0] own_value_i,
  input  logic [ValW-1:0]        cond_var_i,
  input  logic signed [ValW-1:0] weight_i,
  input  logic [IdxW-1:0]        neighbour_i,
  input  logic                   has_term_i,
  input  logic                   last_term_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [IdxW-1:0]        location_out_o,
  output logic signed [ValW-1:0] value_out_o,
  output logic [StatW-1:0]       status_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i
);

  nwc_cmd_t  cmd;
  nwc_stat_t stat;
  logic      dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DirWhiten;
    end else if (cfg_valid_i) begin
      dir_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  nwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nwc_dp #(.NUM_LOCATIONS(NUM_LOCATIONS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .dir_i          (dir_q),
    .location_i     (location_i),
    .own_value_i    (own_value_i),
    .cond_var_i     (cond_var_i),
    .weight_i       (weight_i),
    .neighbour_i    (neighbour_i),
    .has_term_i     (has_term_i),
    .last_term_i    (last_term_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .location_out_o (location_out_o),
    .value_out_o    (value_out_o),
    .status_o       (status_o)
  );

endmodule

### rtl/nwc_ram.sv
// nwc_ram: generic single write port, single read port ram with registered read
// no dependencies
module nwc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/nwc_ctrl.sv
// nwc_ctrl: sequencer for term accumulation, square root, divide and finish
// depends on nwc_pkg
module nwc_ctrl
  import nwc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  nwc_stat_t stat_i,
  output nwc_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    StIdle, StRead, StMul, StAcc, StChk, StSqrt, StDivInit, StDiv,
    StColMul, StColAcc, StFin
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_valid_i) state_q <= StRead;
        end
        StRead: begin
          state_q <= stat_i.has_term ? StMul : StChk;
        end
        StMul: state_q <= StAcc;
        StAcc: state_q <= StChk;
        StChk: begin
          priority if (!stat_i.last_term) begin
            state_q <= StIdle;
          end else if (stat_i.zero_var) begin
            state_q <= StFin;
          end else begin
            state_q <= StSqrt;
            cnt_q   <= SqrtIters;
          end
        end
        StSqrt: begin
          if (cnt_q == '0) begin
            state_q <= (stat_i.dir == DirColor) ? StColMul : StDivInit;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        StDivInit: begin
          state_q <= StDiv;
          cnt_q   <= DivIters;
        end
        StDiv: begin
          if (cnt_q == '0) state_q <= StFin;
          else cnt_q <= cnt_q - 1'b1;
        end
        StColMul: state_q <= StColAcc;
        StColAcc: state_q <= StFin;
        StFin: begin
          if (stat_i.out_free) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == StIdle) && in_valid_i;
    cmd_o.mul_term  = (state_q == StMul);
    cmd_o.acc_term  = (state_q == StAcc);
    cmd_o.sqrt_init = (state_q == StChk) && stat_i.last_term && !stat_i.zero_var;
    cmd_o.sqrt_step = (state_q == StSqrt);
    cmd_o.div_init  = (state_q == StDivInit);
    cmd_o.div_step  = (state_q == StDiv);
    cmd_o.mul_col   = (state_q == StColMul);
    cmd_o.acc_col   = (state_q == StColAcc);
    cmd_o.finish    = (state_q == StFin) && stat_i.out_free;
  end

endmodule

### rtl/nwc_dp.sv
// nwc_dp: datapath with value store, shared multiplier, square root and divider
// depends on nwc_pkg and nwc_ram
module nwc_dp
  import nwc_pkg::*;
#(
  parameter int unsigned NUM_LOCATIONS = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  nwc_cmd_t               cmd_i,
  output nwc_stat_t              stat_o,
  input  logic                   dir_i,
  input  logic [IdxW-1:0]        location_i,
  input  logic signed [ValW-1:0] own_value_i,
  input  logic [ValW-1:0]        cond_var_i,
  input  logic signed [ValW-1:0] weight_i,
  input  logic [IdxW-1:0]        neighbour_i,
  input  logic                   has_term_i,
  input  logic                   last_term_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [IdxW-1:0]        location_out_o,
  output logic signed [ValW-1:0] value_out_o,
  output logic [StatW-1:0]       status_o
);

  localparam int unsigned AddrW = $clog2(NUM_LOCATIONS);

  logic [IdxW-1:0]        loc_q, nb_q;
  logic signed [ValW-1:0] own_q, w_q;
  logic [ValW-1:0]        var_q;
  logic                   has_q, last_q, nb_ok_q, loc_ok_q;
  logic signed [SumW-1:0] sum_q, prod_q, acc_q;
  logic                   ssat_q, nsat_q, neg_q;
  logic [2*RootW-1:0]     xsh_q;
  logic [RootW:0]         rem_q;
  logic [RootW-1:0]       root_q;
  logic [SumW-1:0]        qd_q;
  logic [RootW:0]         drem_q;
  logic                   out_valid_q;
  logic [IdxW-1:0]        loc_out_q;
  logic signed [ValW-1:0] val_out_q;
  logic [StatW-1:0]       stat_out_q;

  logic [ValW-1:0]        rdata;
  logic [AddrW-1:0]       raddr, waddr;
  logic                   we;

  logic signed [ValW:0]     mul_a, mul_b;
  logic signed [2*ValW+1:0] mul_p;
  logic signed [SumW:0]     add_a, add_b, add_s;
  logic signed [SumW-1:0]   add_c;
  logic                     add_ovf;
  logic signed [SumW+1:0]   num_x;
  logic signed [SumW-1:0]   num_c;
  logic                     num_ovf;
  logic [SumW-1:0]          num_mag;
  logic [RootW+2:0]         sq_r, sq_t;
  logic                     sq_ge;
  logic [RootW:0]           dv_t;
  logic                     dv_ge;
  logic [ValW:0]            q_c;
  logic signed [ValW-1:0]   fin_val;
  logic                     fin_sat;
  logic signed [SumW-1:0]   acc_rnd;
  logic                     out_free;

  localparam logic signed [SumW-1:0] ColTop = (64'sd1 <<< 47) - 64'sd32768;
  localparam logic signed [SumW-1:0] ColBot = -(64'sd1 <<< 47) - 64'sd32768;
  localparam logic [ValW:0]          QMax   = 33'h1_0000_0000 >> 1;

  assign raddr = AddrW'({20'b0, nb_q});
  assign waddr = AddrW'({20'b0, loc_q});
  assign we    = cmd_i.finish && loc_ok_q;

  nwc_ram #(.Width(ValW), .Depth(NUM_LOCATIONS)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ((dir_i == DirColor) ? fin_val : own_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // shared multiplier
  always_comb begin
    if (cmd_i.mul_col) begin
      mul_a = {own_q[ValW-1], own_q};
      mul_b = {9'b0, root_q};
    end else begin
      mul_a = {w_q[ValW-1], w_q};
      mul_b = nb_ok_q ? {rdata[ValW-1], rdata} : '0;
    end
    mul_p = mul_a * mul_b;
  end

  // saturating 64-bit add
  always_comb begin
    add_a   = {sum_q[SumW-1], sum_q};
    add_b   = {prod_q[SumW-1], prod_q};
    add_s   = add_a + add_b;
    add_ovf = add_s[SumW] != add_s[SumW-1];
    if (add_ovf) add_c = add_s[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    else add_c = add_s[SumW-1:0];
  end

  // whiten numerator
  always_comb begin
    num_x   = $signed({{18{own_q[ValW-1]}}, own_q, 16'b0}) - $signed({{2{sum_q[SumW-1]}}, sum_q});
    num_ovf = !((num_x[SumW+1:SumW-1] == 3'b000) || (num_x[SumW+1:SumW-1] == 3'b111));
    if (num_ovf) num_c = num_x[SumW+1] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    else num_c = num_x[SumW-1:0];
    num_mag = num_c[SumW-1] ? (SumW'(0) - num_c) : num_c;
  end

  // square root and divide steps
  always_comb begin
    sq_r  = {rem_q, xsh_q[2*RootW-1 -: 2]};
    sq_t  = {1'b0, root_q, 2'b01};
    sq_ge = sq_r >= sq_t;
    dv_t  = {drem_q[RootW-1:0], qd_q[SumW-1]};
    dv_ge = dv_t >= {1'b0, root_q};
  end

  // final value
  always_comb begin
    fin_val = '0;
    fin_sat = 1'b0;
    q_c     = (qd_q > 64'(QMax)) ? QMax : qd_q[ValW:0];
    acc_rnd = acc_q + 64'sd32768;
    if (dir_i == DirWhiten) begin
      if (neg_q) begin
        fin_val = ValW'(33'd0 - q_c);
        fin_sat = nsat_q;
      end else if (q_c >= QMax) begin
        fin_val = {1'b0, {(ValW-1){1'b1}}};
        fin_sat = 1'b1;
      end else begin
        fin_val = q_c[ValW-1:0];
        fin_sat = nsat_q;
      end
    end else begin
      if (acc_q >= ColTop) begin
        fin_val = {1'b0, {(ValW-1){1'b1}}};
        fin_sat = 1'b1;
      end else if (acc_q < ColBot) begin
        fin_val = {1'b1, {(ValW-1){1'b0}}};
        fin_sat = 1'b1;
      end else begin
        fin_val = acc_rnd[16 +: ValW];
        fin_sat = nsat_q;
      end
    end
    if (var_q == '0) begin
      fin_val = '0;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      loc_q    <= location_i;
      own_q    <= own_value_i;
      var_q    <= cond_var_i;
      w_q      <= weight_i;
      nb_q     <= neighbour_i;
      has_q    <= has_term_i;
      last_q   <= last_term_i;
      nb_ok_q  <= 32'(neighbour_i) < NUM_LOCATIONS;
      loc_ok_q <= 32'(location_i) < NUM_LOCATIONS;
    end
    if (cmd_i.mul_term || cmd_i.mul_col) prod_q <= mul_p[SumW-1:0];
    if (cmd_i.sqrt_init) begin
      xsh_q  <= {var_q, 16'b0};
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      xsh_q  <= {xsh_q[2*RootW-3:0], 2'b00};
      rem_q  <= sq_ge ? (RootW+1)'(sq_r - sq_t) : sq_r[RootW:0];
      root_q <= {root_q[RootW-2:0], sq_ge};
    end
    if (cmd_i.div_init) begin
      qd_q   <= num_mag + SumW'(root_q >> 1);
      drem_q <= '0;
      neg_q  <= num_c[SumW-1];
      nsat_q <= ssat_q | num_ovf;
    end
    if (cmd_i.div_step) begin
      drem_q <= dv_ge ? (dv_t - {1'b0, root_q}) : dv_t;
      qd_q   <= {qd_q[SumW-2:0], dv_ge};
    end
    if (cmd_i.acc_col) begin
      acc_q  <= add_c;
      nsat_q <= ssat_q | add_ovf;
    end
    if (cmd_i.finish) begin
      loc_out_q  <= loc_q;
      val_out_q  <= fin_val;
      stat_out_q <= (var_q == '0) ? StatZeroVar : (fin_sat ? StatSat : StatOk);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      ssat_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc_term) begin
        sum_q  <= add_c;
        ssat_q <= ssat_q | add_ovf;
      end
      if (cmd_i.finish) begin
        sum_q  <= '0;
        ssat_q <= 1'b0;
      end
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.has_term  = has_q;
  assign stat_o.last_term = last_q;
  assign stat_o.zero_var  = (var_q == '0);
  assign stat_o.out_free  = out_free;
  assign stat_o.dir       = dir_i;

  assign out_valid_o    = out_valid_q;
  assign location_out_o = loc_out_q;
  assign value_out_o    = val_out_q;
  assign status_o       = stat_out_q;

endmodule
